// ===== hw/rtl/rmms_pkg.sv =====
// Shared types, constants and the mask point table of the rotating-mask smoother.
`default_nettype none

package rmms_pkg;

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned CFG_W         = 12;
  localparam int unsigned ROW_W         = 12;
  localparam int unsigned DEF_MAX_WIDTH = 2048;

  localparam logic [CFG_W-1:0] FW_RESET = 12'd640;
  localparam logic [CFG_W-1:0] FH_RESET = 12'd480;

  // mask accumulators: up to 9 points of 8 bits
  localparam int unsigned SUM_W = 12;
  localparam int unsigned SQ_W  = 20;
  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] MAX_PTS = 4'd9;

  // divider: widest dividend is sum*sum (< 2^23), divisor is a point count
  localparam int unsigned DIV_W = 23;
  localparam int unsigned DVS_W = CNT_W;

  localparam int unsigned STEP_W = 7;
  localparam logic [3:0]  MASK_LAST = 4'd8;

  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] in_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             out_last;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic signed [2:0] dx;
    logic signed [2:0] dy;
    logic              last;
  } mask_pt_t;

  // 65 points: eight rotated 7-point masks, then the 3x3 square
  function automatic mask_pt_t mask_point(input logic [STEP_W-1:0] idx);
    int       dx;
    int       dy;
    mask_pt_t r;
    dx = 0;
    dy = 0;
    case (idx)
      7'd0:  begin dx = -1; dy =  2; end
      7'd1:  begin dx =  0; dy =  2; end
      7'd2:  begin dx =  1; dy =  2; end
      7'd3:  begin dx =  0; dy =  1; end
      7'd4:  begin dx =  0; dy =  0; end
      7'd5:  begin dx =  0; dy = -1; end
      7'd6:  begin dx =  0; dy = -2; end
      7'd7:  begin dx =  1; dy =  2; end
      7'd8:  begin dx =  2; dy =  2; end
      7'd9:  begin dx =  2; dy =  1; end
      7'd10: begin dx =  1; dy =  1; end
      7'd11: begin dx =  0; dy =  0; end
      7'd12: begin dx = -1; dy = -1; end
      7'd13: begin dx = -2; dy = -2; end
      7'd14: begin dx =  2; dy =  1; end
      7'd15: begin dx =  2; dy =  0; end
      7'd16: begin dx =  2; dy = -1; end
      7'd17: begin dx =  1; dy =  0; end
      7'd18: begin dx =  0; dy =  0; end
      7'd19: begin dx = -1; dy =  0; end
      7'd20: begin dx = -2; dy =  0; end
      7'd21: begin dx =  2; dy = -1; end
      7'd22: begin dx =  2; dy = -2; end
      7'd23: begin dx =  1; dy = -2; end
      7'd24: begin dx =  1; dy = -1; end
      7'd25: begin dx =  0; dy =  0; end
      7'd26: begin dx = -1; dy =  1; end
      7'd27: begin dx = -2; dy =  2; end
      7'd28: begin dx =  1; dy = -2; end
      7'd29: begin dx =  0; dy = -2; end
      7'd30: begin dx = -1; dy = -2; end
      7'd31: begin dx =  0; dy = -1; end
      7'd32: begin dx =  0; dy =  0; end
      7'd33: begin dx =  0; dy =  1; end
      7'd34: begin dx =  0; dy =  2; end
      7'd35: begin dx = -1; dy = -2; end
      7'd36: begin dx = -2; dy = -2; end
      7'd37: begin dx = -2; dy = -1; end
      7'd38: begin dx = -1; dy = -1; end
      7'd39: begin dx =  0; dy =  0; end
      7'd40: begin dx =  1; dy =  1; end
      7'd41: begin dx =  2; dy =  2; end
      7'd42: begin dx = -2; dy = -1; end
      7'd43: begin dx = -2; dy =  0; end
      7'd44: begin dx = -2; dy =  1; end
      7'd45: begin dx = -1; dy =  0; end
      7'd46: begin dx =  0; dy =  0; end
      7'd47: begin dx =  1; dy =  0; end
      7'd48: begin dx =  2; dy =  0; end
      7'd49: begin dx = -2; dy =  1; end
      7'd50: begin dx = -2; dy =  2; end
      7'd51: begin dx = -1; dy =  2; end
      7'd52: begin dx = -1; dy =  1; end
      7'd53: begin dx =  0; dy =  0; end
      7'd54: begin dx =  1; dy = -1; end
      7'd55: begin dx =  2; dy = -2; end
      7'd56: begin dx = -1; dy = -1; end
      7'd57: begin dx =  0; dy = -1; end
      7'd58: begin dx =  1; dy = -1; end
      7'd59: begin dx = -1; dy =  0; end
      7'd60: begin dx =  0; dy =  0; end
      7'd61: begin dx =  1; dy =  0; end
      7'd62: begin dx = -1; dy =  1; end
      7'd63: begin dx =  0; dy =  1; end
      7'd64: begin dx =  1; dy =  1; end
      default: begin dx = 0; dy = 0; end
    endcase
    r.dx   = 3'(dx);
    r.dy   = 3'(dy);
    r.last = (idx == 7'd6)  || (idx == 7'd13) || (idx == 7'd20) || (idx == 7'd27) ||
             (idx == 7'd34) || (idx == 7'd41) || (idx == 7'd48) || (idx == 7'd55) ||
             (idx == 7'd64);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rmms_store.sv =====
// Pixel ring memory: one write port, one read port with registered data.
`default_nettype none

module rmms_store import rmms_pkg::*; #(
  parameter int unsigned DEPTH = 5 * DEF_MAX_WIDTH,
  parameter int unsigned AW    = $clog2(5 * DEF_MAX_WIDTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [PIX_W-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [PIX_W-1:0] rdata_o
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rmms_rem.sv =====
// Ring remainder of a linear pixel index by reciprocal multiplication.
`default_nettype none

module rmms_rem import rmms_pkg::*; #(
  parameter int unsigned X_W     = 24,
  parameter int unsigned R_W     = 14,
  parameter int unsigned MODULUS = 5 * DEF_MAX_WIDTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [X_W-1:0] x_i,
  output unit_stat_t          stat_o,
  output logic      [R_W-1:0] rem_o
);

  // floor(x * RECIP / 2^SH) is the quotient or one below it for any x < 2^X_W
  localparam int unsigned     SH      = X_W + $clog2(MODULUS);
  localparam int unsigned     PW      = 2 * X_W + 1;
  localparam longint unsigned RECIP_L = (64'd1 << SH) / 64'(MODULUS);
  localparam logic [X_W:0]    RECIP   = (X_W + 1)'(RECIP_L);
  localparam logic [X_W-1:0]  MOD_X   = X_W'(MODULUS);
  localparam logic [R_W:0]    MOD_C   = (R_W + 1)'(MODULUS);

  logic [X_W-1:0] x_q, quo_q;
  logic [R_W:0]   r_q;
  logic           ph1_q, ph2_q, done_q;
  logic [PW-1:0]  prod;
  logic [X_W-1:0] back;

  assign prod = PW'(x_q) * PW'(RECIP);
  assign back = X_W'(quo_q * MOD_X);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph1_q  <= 1'b0;
      ph2_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ph1_q  <= start_i;
      ph2_q  <= ph1_q;
      done_q <= ph2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
    end
    if (ph1_q) begin
      quo_q <= X_W'(prod >> SH);
    end
    // partial remainder is below twice the modulus
    if (ph2_q) begin
      r_q <= (R_W + 1)'(x_q - back);
    end
  end

  assign stat_o.busy = ph1_q | ph2_q;
  assign stat_o.done = done_q;
  assign rem_o       = (r_q >= MOD_C) ? R_W'(r_q - MOD_C) : r_q[R_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/rmms_div.sv =====
// Bit-serial restoring divider by a small point count (1 to 9).
`default_nettype none

module rmms_div import rmms_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output unit_stat_t            stat_o,
  output logic      [DIV_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] x_q;
  logic [DVS_W-1:0] r_q, d_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  assign trial = {r_q, x_q[DIV_W-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = (trial >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      x_q <= {x_q[DIV_W-2:0], ge};
      r_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = x_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rotating_mask_min_variance_smoother_unit.sv =====
// Top level of the rotating-mask minimum-variance smoother.
//
//   port group   | direction | transfer when               | payload
//   -------------+-----------+-----------------------------+------------------------
//   in_*         | in        | in_valid_i & !in_stall_o    | in_item_t (req, pixel)
//   out_*        | out       | out_valid_o & !out_stall_i  | out_item_t (pixel, last)
//   APB          | in        | psel & penable & pwrite     | width @0x0, height @0x4
//
// One item at a time. A push without a result passes through the two index states,
// the ring remainder and the store write from one transfer to the next. An item with
// a result adds 65 mask steps, each reading the store if its point lies in the image,
// plus up to 19 divides on the shared divider. Reset clears counters and registers
// only; the store has no clearing pass. A result waits in the output register while
// the next item is taken; a new result waits in its final state until that register
// is free.
`default_nettype none

module rotating_mask_min_variance_smoother_unit import rmms_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o
);

  localparam int unsigned DEPTH = 5 * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EW    = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
  localparam int unsigned WW    = $clog2(EW + 1);
  localparam int unsigned COL_W = $clog2(EW);
  localparam int unsigned LIN_W = ROW_W + WW;
  localparam int unsigned SW    = AW + 2;
  localparam int unsigned XS_W  = WW + 2;
  localparam int unsigned YS_W  = ROW_W + 2;
  localparam logic signed [SW-1:0] DEPTH_S = SW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_LINP, S_LINQ, S_MOD, S_RD, S_DRAIN, S_V1, S_V1W,
    S_V2, S_V2W, S_CMP, S_MS, S_MW, S_OUT
  } state_e;

  // configuration
  logic [CFG_W-1:0] fw_q, fh_q;
  logic [WW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FW_RESET;
      fh_q <= FH_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_WIDTH:  fw_q <= pwdata[CFG_W-1:0];
        REG_HEIGHT: fh_q <= pwdata[CFG_W-1:0];
        default:    fw_q <= fw_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, fw_q};
      REG_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, fh_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    priority if (fw_q == '0) begin
      eff_w = WW'(1);
    end else if (fw_q > CFG_W'(EW)) begin
      eff_w = WW'(EW);
    end else begin
      eff_w = WW'(fw_q);
    end
  end

  assign eff_h = (fh_q == '0) ? ROW_W'(1) : fh_q;

  // control and datapath registers
  state_e           state_q;
  logic             is_push_q;
  logic [PIX_W-1:0] pix_q;
  logic [COL_W-1:0] in_col_q, out_col_q;
  logic [ROW_W-1:0] in_row_q, out_row_q;
  logic [LIN_W-1:0] lin_p_q, lin_q_q;
  logic [STEP_W-1:0] step_q;
  logic [3:0]       mask_q;
  logic             rd_pend_q;
  logic [SUM_W-1:0] acc_sum_q, best_sum_q;
  logic [SQ_W-1:0]  acc_sq_q, t_q, var_q, best_var_q;
  logic [CNT_W-1:0] acc_cnt_q, best_cnt_q;
  logic [PIX_W-1:0] res_q;
  logic             out_valid_q;
  out_item_t        out_q;

  // shared multiplier for the two linear indexes
  logic [ROW_W-1:0] mul_row;
  logic [COL_W-1:0] mul_col;
  logic [LIN_W-1:0] lin_mul;

  assign mul_row = (state_q == S_LINP) ? in_row_q : out_row_q;
  assign mul_col = (state_q == S_LINP) ? in_col_q : out_col_q;
  assign lin_mul = LIN_W'(mul_row) * LIN_W'(eff_w) + LIN_W'(mul_col);

  // ring remainders of the write and center indexes
  unit_stat_t    prem_stat, qrem_stat;
  logic [AW-1:0] p_rem, q_rem;
  logic          rem_start;

  assign rem_start = (state_q == S_LINQ);

  rmms_rem #(.X_W(LIN_W), .R_W(AW), .MODULUS(DEPTH)) u_prem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .x_i     (lin_p_q),
    .stat_o  (prem_stat),
    .rem_o   (p_rem)
  );

  rmms_rem #(.X_W(LIN_W), .R_W(AW), .MODULUS(DEPTH)) u_qrem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .x_i     (lin_mul),
    .stat_o  (qrem_stat),
    .rem_o   (q_rem)
  );

  // window point for the current step
  mask_pt_t                pt;
  logic signed [XS_W-1:0]  x_s;
  logic signed [YS_W-1:0]  y_s;
  logic                    in_img;
  logic signed [SW-1:0]    w_s, dyw, a_s;
  logic [AW-1:0]           rd_addr;

  assign pt  = mask_point(step_q);
  assign x_s = $signed({2'b00, WW'(out_col_q)}) + XS_W'(pt.dx);
  assign y_s = $signed({2'b00, out_row_q}) + YS_W'(pt.dy);
  assign in_img = (x_s >= 0) && (x_s < $signed({2'b00, eff_w})) &&
                  (y_s >= 0) && (y_s < $signed({2'b00, eff_h}));
  assign w_s = $signed({{(SW-WW){1'b0}}, eff_w});

  always_comb begin
    unique case (pt.dy)
      -3'sd2:  dyw = -(w_s <<< 1);
      -3'sd1:  dyw = -w_s;
      3'sd1:   dyw = w_s;
      3'sd2:   dyw = w_s <<< 1;
      default: dyw = '0;
    endcase
    a_s = $signed({2'b00, q_rem}) + dyw + SW'(pt.dx);
    // offset stays within one ring depth, one correction suffices
    priority if (a_s < 0) begin
      rd_addr = AW'(a_s + DEPTH_S);
    end else if (a_s >= DEPTH_S) begin
      rd_addr = AW'(a_s - DEPTH_S);
    end else begin
      rd_addr = AW'(a_s);
    end
  end

  // line store
  logic             st_we, st_re;
  logic [PIX_W-1:0] rd_data;

  assign st_we = (state_q == S_MOD) && qrem_stat.done && is_push_q;
  assign st_re = (state_q == S_RD) && in_img;

  rmms_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (p_rem),
    .wdata_i (pix_q),
    .re_i    (st_re),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // shared divider
  unit_stat_t       div_stat;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [DVS_W-1:0] div_divisor;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(acc_sum_q * acc_sum_q);
    div_divisor  = acc_cnt_q;
    unique case (state_q)
      S_V1: begin
        div_start = (acc_cnt_q != '0);
      end
      S_V2: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(t_q);
      end
      S_MS: begin
        div_start    = (best_cnt_q != '0);
        div_dividend = DIV_W'(best_sum_q);
        div_divisor  = best_cnt_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  rmms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quo_o      (div_quo)
  );

  // status of counters
  logic in_done, flush_ok, emit_ok, in_wrap, out_wrap, out_last;

  assign in_done  = (in_row_q >= eff_h);
  assign flush_ok = in_done && (out_row_q < eff_h);
  assign emit_ok  = ((LIN_W+1)'(lin_q_q) + (LIN_W+1)'({eff_w, 1'b0}) + (LIN_W+1)'(2))
                    <= (LIN_W+1)'(lin_p_q);
  assign in_wrap  = ((WW+1)'(in_col_q) + (WW+1)'(1)) >= (WW+1)'(eff_w);
  assign out_wrap = ((WW+1)'(out_col_q) + (WW+1)'(1)) >= (WW+1)'(eff_w);
  assign out_last = out_wrap &&
                    (((ROW_W+1)'(out_row_q) + (ROW_W+1)'(1)) >= (ROW_W+1)'(eff_h));

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      is_push_q   <= 1'b0;
      pix_q       <= '0;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      lin_p_q     <= '0;
      lin_q_q     <= '0;
      step_q      <= '0;
      mask_q      <= '0;
      rd_pend_q   <= 1'b0;
      acc_sum_q   <= '0;
      acc_sq_q    <= '0;
      acc_cnt_q   <= '0;
      best_sum_q  <= '0;
      best_var_q  <= '0;
      best_cnt_q  <= '0;
      t_q         <= '0;
      var_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      rd_pend_q <= st_re;
      if (rd_pend_q) begin
        acc_sum_q <= acc_sum_q + SUM_W'(rd_data);
        acc_sq_q  <= acc_sq_q + SQ_W'(rd_data * rd_data);
        acc_cnt_q <= acc_cnt_q + CNT_W'(1);
      end
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_data_i.req_type == REQ_FLUSH) begin
              if (flush_ok) begin
                is_push_q <= 1'b0;
                state_q   <= S_LINQ;
              end
            end else if (!in_done) begin
              is_push_q <= 1'b1;
              pix_q     <= in_data_i.in_pixel;
              state_q   <= S_LINP;
            end
          end
        end
        S_LINP: begin
          lin_p_q <= lin_mul;
          state_q <= S_LINQ;
        end
        S_LINQ: begin
          lin_q_q <= lin_mul;
          state_q <= S_MOD;
        end
        S_MOD: begin
          if (qrem_stat.done) begin
            if (is_push_q) begin
              if (in_wrap) begin
                in_col_q <= '0;
                in_row_q <= in_row_q + ROW_W'(1);
              end else begin
                in_col_q <= in_col_q + COL_W'(1);
              end
            end
            if (!is_push_q || emit_ok) begin
              step_q     <= '0;
              mask_q     <= '0;
              acc_sum_q  <= '0;
              acc_sq_q   <= '0;
              acc_cnt_q  <= '0;
              // all ones exceeds any mask variance, so mask 0 always takes it
              best_var_q <= '1;
              best_sum_q <= '0;
              best_cnt_q <= '0;
              state_q    <= S_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_RD: begin
          step_q <= step_q + STEP_W'(1);
          if (pt.last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_V1;
        end
        S_V1: begin
          if (acc_cnt_q == '0) begin
            var_q   <= '0;
            state_q <= S_CMP;
          end else begin
            state_q <= S_V1W;
          end
        end
        S_V1W: begin
          if (div_stat.done) begin
            t_q     <= acc_sq_q - SQ_W'(div_quo);
            state_q <= S_V2;
          end
        end
        S_V2: begin
          state_q <= S_V2W;
        end
        S_V2W: begin
          if (div_stat.done) begin
            var_q   <= SQ_W'(div_quo);
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (var_q < best_var_q) begin
            best_var_q <= var_q;
            best_sum_q <= acc_sum_q;
            best_cnt_q <= acc_cnt_q;
          end
          if (mask_q == MASK_LAST) begin
            state_q <= S_MS;
          end else begin
            mask_q    <= mask_q + 4'd1;
            acc_sum_q <= '0;
            acc_sq_q  <= '0;
            acc_cnt_q <= '0;
            state_q   <= S_RD;
          end
        end
        S_MS: begin
          if (best_cnt_q == '0) begin
            res_q   <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_MW;
          end
        end
        S_MW: begin
          if (div_stat.done) begin
            res_q   <= div_quo[PIX_W-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q     <= 1'b1;
            out_q.out_pixel <= res_q;
            out_q.out_last  <= out_last;
            if (out_last) begin
              in_col_q  <= '0;
              in_row_q  <= '0;
              out_col_q <= '0;
              out_row_q <= '0;
            end else if (out_wrap) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + ROW_W'(1);
            end else begin
              out_col_q <= out_col_q + COL_W'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_out_from_fsm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result appeared outside the output state");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_cnt_q <= MAX_PTS)
    else $error("mask point count above nine");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_rem_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prem_stat.done == qrem_stat.done)
    else $error("remainder units out of step");

endmodule

`default_nettype wire
